// ===== rtl/wse_pkg.sv =====
// ----------------------------------------------------------------------------
// wse_pkg
// Shared types and constants for the watchdog supervisor with early warning.
// ----------------------------------------------------------------------------
package wse_pkg;

   // command codes carried in req_tuser
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_FEED    = 2'd1;
   localparam logic [1:0] CMD_ENABLE  = 2'd2;
   localparam logic [1:0] CMD_DISABLE = 2'd3;

   // reported mode
   localparam logic [1:0] MODE_DISABLED = 2'd0;
   localparam logic [1:0] MODE_ENABLED  = 2'd1;
   localparam logic [1:0] MODE_FEEDING  = 2'd2;
   localparam logic [1:0] MODE_WARNING  = 2'd3;

   // warning actions
   localparam logic [1:0] ACT_RESET = 2'd0;

   // register indexes
   localparam int unsigned REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_FEED_INTERVAL  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_WARN_THRESHOLD = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_AUTO_FEED_ON   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_EARLY_WARN_ON  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DEFAULT_ACTION = 3'd4;

   localparam logic [23:0] TIMEOUT_LOW  = 24'd1000;
   localparam logic [23:0] TIMEOUT_HIGH = 24'h7FFFFF;
   localparam logic [22:0] REMAIN_MAX   = 23'h7FFFFF;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [23:0] enable_timeout;
      logic        feed_veto;
      logic        override_valid;
      logic [1:0]  override_action;
   } item_type;

   // first member in the top bits, so accepted lands in bit 0
   typedef struct packed {
      logic [3:0]  pad;
      logic [31:0] interval_avg;
      logic [31:0] interval_max;
      logic [31:0] interval_min;
      logic [31:0] warning_total;
      logic [31:0] missed_total;
      logic [31:0] feed_total;
      logic [31:0] since_feed_ms;
      logic [22:0] time_left;
      logic        reset_request;
      logic        warning_event;
      logic [1:0]  mode;
      logic        accepted;
   } result_type;

   typedef struct packed {
      logic                 we;
      logic [REG_IDX_W-1:0] idx;
      logic [31:0]          data;
   } cfg_write_type;

   typedef struct packed {
      logic [22:0] feed_period;
      logic [22:0] warning_threshold;
      logic        auto_feed_on;
      logic        early_warning_on;
      logic [1:0]  warn_action;
   } cfg_regs_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic mul;
      logic div_start;
      logic avg_load;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_avg;
      logic div_done;
   } ctrl_status_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_SUM  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

endpackage

// ===== rtl/wse_div.sv =====
// ----------------------------------------------------------------------------
// wse_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in 32 bits, so the upper half of the dividend seeds the partial remainder.
// ----------------------------------------------------------------------------
module wse_div
   import wse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [32:0] den,
   output logic        done,
   output logic [31:0] quot
);

   logic [32:0] rem_ff, rem_in;
   logic [31:0] qs_ff, qs_in;
   logic [32:0] den_ff;
   logic [4:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] rem_sh;
   logic [33:0] diff;
   logic        ge;

   always_comb begin
      rem_sh = {rem_ff, qs_ff[31]};
      diff   = rem_sh - {1'b0, den_ff};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in   = rem_ff;
      qs_in    = qs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = {1'b0, num[63:32]};
         qs_in    = num[31:0];
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[32:0] : rem_sh[32:0];
         qs_in    = {qs_ff[30:0], ge};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      qs_ff  <= qs_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quot = qs_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

// ===== rtl/wse_dp.sv =====
// ----------------------------------------------------------------------------
// wse_dp
// Datapath: watchdog state, statistics, configuration registers, the
// running-average multiply and divide, and the result register.
// ----------------------------------------------------------------------------
module wse_dp
   import wse_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  item_type        req_item,
   input  cfg_write_type   cfg_wr,
   input  ctrl_cmd_type    ctl,
   output ctrl_status_type status,
   output cfg_regs_type    cfg,
   output result_type      result
);

   cfg_regs_type cfg_ff, cfg_in;
   item_type     item_ff;

   logic [31:0] now_ff, now_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [31:0] next_feed_ff, next_feed_in;
   logic [31:0] last_feed_ff, last_feed_in;
   logic [22:0] active_ff, active_in;
   logic        armed_ff, armed_in;
   logic        warned_ff, warned_in;
   logic        stopped_ff, stopped_in;
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] feeds_ff, feeds_in;
   logic [31:0] misses_ff, misses_in;
   logic [31:0] warnings_ff, warnings_in;
   logic [31:0] min_ff, min_in;
   logic [31:0] max_ff, max_in;
   logic [31:0] avg_ff, avg_in;

   logic        acc_ff, acc_in;
   logic        wev_ff, wev_in;
   logic        rreq_ff, rreq_in;

   logic [31:0] gap_ff, fo_ff;
   logic [63:0] prod_ff;
   logic [31:0] gap;
   logic [31:0] rem_w;
   logic [1:0]  act;
   logic        feed_try;
   logic        need_avg;

   logic [31:0] quot;
   logic        div_done;
   logic [31:0] left_ms;
   logic [22:0] remaining;
   result_type  result_ff;

   wse_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_start),
      .num   (prod_ff + {32'd0, gap_ff}),
      .den   ({1'b0, fo_ff} + 33'd1),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      cfg_in       = cfg_ff;
      now_in       = now_ff;
      deadline_in  = deadline_ff;
      next_feed_in = next_feed_ff;
      last_feed_in = last_feed_ff;
      active_in    = active_ff;
      armed_in     = armed_ff;
      warned_in    = warned_ff;
      stopped_in   = stopped_ff;
      mode_in      = mode_ff;
      feeds_in     = feeds_ff;
      misses_in    = misses_ff;
      warnings_in  = warnings_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      avg_in       = avg_ff;
      acc_in       = acc_ff;
      wev_in       = wev_ff;
      rreq_in      = rreq_ff;
      feed_try     = 1'b0;
      need_avg     = 1'b0;
      rem_w        = '0;
      act          = item_ff.override_valid ? item_ff.override_action : cfg_ff.warn_action;
      gap          = '0;

      if (cfg_wr.we) begin
         case (cfg_wr.idx)
            REG_FEED_INTERVAL:  cfg_in.feed_period = cfg_wr.data[22:0];
            REG_WARN_THRESHOLD: cfg_in.warning_threshold = cfg_wr.data[22:0];
            REG_AUTO_FEED_ON: begin
               cfg_in.auto_feed_on = cfg_wr.data[0];
               stopped_in          = 1'b0;
            end
            REG_EARLY_WARN_ON:  cfg_in.early_warning_on = cfg_wr.data[0];
            REG_DEFAULT_ACTION: cfg_in.warn_action = cfg_wr.data[1:0];
            default: ;
         endcase
      end

      if (ctl.exec) begin
         acc_in  = 1'b0;
         wev_in  = 1'b0;
         rreq_in = 1'b0;
         case (item_ff.cmd)
            CMD_TICK: begin
               now_in = now_ff + 32'd1;
               if (armed_ff) begin
                  if (cfg_ff.early_warning_on && !warned_ff) begin
                     rem_w = (now_in < deadline_ff) ? deadline_ff - now_in : 32'd0;
                     if (rem_w <= {9'd0, cfg_ff.warning_threshold}) begin
                        warned_in   = 1'b1;
                        warnings_in = warnings_ff + 32'd1;
                        mode_in     = MODE_WARNING;
                        wev_in      = 1'b1;
                        rreq_in     = (act == ACT_RESET);
                     end
                  end
                  // a reset request skips this tick's auto-feed
                  feed_try = !rreq_in && cfg_ff.auto_feed_on && !stopped_ff &&
                             (now_in >= next_feed_ff);
               end
            end
            CMD_FEED: feed_try = 1'b1;
            CMD_ENABLE: begin
               if (item_ff.enable_timeout >= TIMEOUT_LOW &&
                   item_ff.enable_timeout <= TIMEOUT_HIGH) begin
                  active_in    = item_ff.enable_timeout[22:0];
                  armed_in     = 1'b1;
                  mode_in      = MODE_ENABLED;
                  last_feed_in = now_ff;
                  next_feed_in = now_ff + {9'd0, cfg_ff.feed_period};
                  deadline_in  = now_ff + {8'd0, item_ff.enable_timeout};
                  warned_in    = 1'b0;
                  acc_in       = 1'b1;
               end
            end
            CMD_DISABLE: begin
               mode_in    = MODE_DISABLED;
               stopped_in = 1'b1;
               acc_in     = 1'b1;
            end
            default: ;
         endcase

         if (feed_try && armed_ff) begin
            if (item_ff.feed_veto) begin
               misses_in = misses_ff + 32'd1;
            end else begin
               gap = now_in - last_feed_ff;
               if (feeds_ff == 32'd0) begin
                  min_in = gap;
                  max_in = gap;
                  avg_in = gap;
               end else begin
                  if (gap < min_ff) begin
                     min_in = gap;
                  end
                  if (gap > max_ff) begin
                     max_in = gap;
                  end
                  need_avg = 1'b1;
               end
               feeds_in     = feeds_ff + 32'd1;
               last_feed_in = now_in;
               mode_in      = MODE_FEEDING;
               deadline_in  = now_in + {9'd0, active_ff};
               warned_in    = 1'b0;
               acc_in       = 1'b1;
               if (item_ff.cmd == CMD_TICK) begin
                  next_feed_in = now_in + {9'd0, cfg_ff.feed_period};
               end
            end
         end
      end

      if (ctl.avg_load) begin
         avg_in = quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feed_period       <= 23'd1000;
         cfg_ff.warning_threshold <= 23'd1000;
         cfg_ff.auto_feed_on      <= 1'b1;
         cfg_ff.early_warning_on  <= 1'b1;
         cfg_ff.warn_action       <= ACT_RESET;
         now_ff       <= '0;
         deadline_ff  <= '0;
         next_feed_ff <= '0;
         last_feed_ff <= '0;
         active_ff    <= '0;
         armed_ff     <= 1'b0;
         warned_ff    <= 1'b0;
         stopped_ff   <= 1'b0;
         mode_ff      <= MODE_DISABLED;
         feeds_ff     <= '0;
         misses_ff    <= '0;
         warnings_ff  <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         avg_ff       <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         now_ff       <= now_in;
         deadline_ff  <= deadline_in;
         next_feed_ff <= next_feed_in;
         last_feed_ff <= last_feed_in;
         active_ff    <= active_in;
         armed_ff     <= armed_in;
         warned_ff    <= warned_in;
         stopped_ff   <= stopped_in;
         mode_ff      <= mode_in;
         feeds_ff     <= feeds_in;
         misses_ff    <= misses_in;
         warnings_ff  <= warnings_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         avg_ff       <= avg_in;
      end
   end

   always_comb begin
      left_ms = deadline_ff - now_ff;
      if (!armed_ff || now_ff >= deadline_ff) begin
         remaining = '0;
      end else if (left_ms > {9'd0, REMAIN_MAX}) begin
         remaining = REMAIN_MAX;
      end else begin
         remaining = left_ms[22:0];
      end
   end

   function automatic result_type result_in();
      result_type r;
      r.pad           = '0;
      r.interval_avg  = avg_ff;
      r.interval_max  = max_ff;
      r.interval_min  = min_ff;
      r.warning_total = warnings_ff;
      r.missed_total  = misses_ff;
      r.feed_total    = feeds_ff;
      r.since_feed_ms = now_ff - last_feed_ff;
      r.time_left     = remaining;
      r.reset_request = rreq_ff;
      r.warning_event = wev_ff;
      r.mode          = mode_ff;
      r.accepted      = acc_ff;
      return r;
   endfunction

   // payload: item, per-item flags, average operands, result
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      wev_ff  <= wev_in;
      rreq_ff <= rreq_in;
      if (ctl.capture) begin
         item_ff <= req_item;
      end
      if (ctl.exec) begin
         gap_ff <= gap;
         fo_ff  <= feeds_ff;
      end
      if (ctl.mul) begin
         prod_ff <= {32'd0, avg_ff} * {32'd0, fo_ff};
      end
      if (ctl.out_load) begin
         result_ff <= result_in();
      end
   end

   assign status.need_avg = need_avg;
   assign status.div_done = div_done;
   assign cfg             = cfg_ff;
   assign result          = result_ff;

   a_warned_armed: assert property (@(posedge clock) disable iff (reset)
      warned_ff |-> armed_ff)
      else $error("warned while not armed");

   a_armed_sticks: assert property (@(posedge clock) disable iff (reset)
      armed_ff |=> armed_ff)
      else $error("watchdog disarmed after start");

   a_avg_bounds: assert property (@(posedge clock) disable iff (reset)
      (feeds_ff != 32'd0) |-> (min_ff <= avg_ff && avg_ff <= max_ff))
      else $error("average feed interval outside min/max");

endmodule

// ===== rtl/wse_ctrl.sv =====
// ----------------------------------------------------------------------------
// wse_ctrl
// Sequencer: takes one command, runs it, walks the running-average multiply
// and divide when a feed needs it, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module wse_ctrl
   import wse_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    ctl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = status.need_avg ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            ctl.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               ctl.avg_load = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (slot_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> slot_free)
      else $error("result loaded over an untaken transfer");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !status.div_done) |=> state_ff == ST_DIV)
      else $error("left divide before quotient ready");

endmodule

// ===== rtl/watchdog_supervisor_early_warning.sv =====
// ----------------------------------------------------------------------------
// watchdog_supervisor_early_warning
// Millisecond watchdog with auto-feed, early warning and feed statistics.
// ----------------------------------------------------------------------------
// Each req transfer carries one command (tick, feed, enable, disable) and
// yields exactly one rsp transfer with the state after that command. Items
// are handled one at a time: a command is captured, executed and then loaded
// into the result register, and the next one is taken only after that load.
// A successful feed that must update the running average also passes through
// a 32x32 multiply, a sum step and a 32-step bit-serial divider before its
// result is loaded. A result that waits on rsp holds the next one in its
// last state for as long as rsp_tready stays low. The next command is taken
// while an earlier result still waits on rsp. Configuration registers sit
// at byte addresses 0, 4, 8, 12, 16 of the csr port and must be written
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module watchdog_supervisor_early_warning
   import wse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // req: tick/feed/enable/disable commands
   input  logic         req_tvalid,
   output logic         req_tready,
   // [23:0] enable_timeout, [24] feed_veto, [25] override_valid,
   // [27:26] override_action, [31:28] zero
   input  logic [31:0]  req_tdata,
   // [1:0] cmd
   input  logic [1:0]   req_tuser,
   // rsp: one result per command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] accepted, [2:1] mode, [3] warning_event, [4] reset_request,
   // [27:5] time_left, [59:28] since_feed_ms, [91:60] feed_total,
   // [123:92] missed_total, [155:124] warning_total, [187:156] interval_min,
   // [219:188] interval_max, [251:220] interval_avg, [255:252] zero
   output logic [255:0] rsp_tdata,
   // csr: register access
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   item_type        req_item;
   cfg_write_type   cfg_wr;
   cfg_regs_type    cfg;
   ctrl_cmd_type    ctl;
   ctrl_status_type status;
   result_type      result;

   assign req_item.cmd             = req_tuser;
   assign req_item.enable_timeout  = req_tdata[23:0];
   assign req_item.feed_veto       = req_tdata[24];
   assign req_item.override_valid  = req_tdata[25];
   assign req_item.override_action = req_tdata[27:26];

   assign csr_pready = 1'b1;
   assign cfg_wr.we   = csr_psel && csr_penable && csr_pwrite;
   assign cfg_wr.idx  = csr_paddr[4:2];
   assign cfg_wr.data = csr_pwdata;

   always_comb begin
      case (csr_paddr[4:2])
         REG_FEED_INTERVAL:  csr_prdata = {9'd0, cfg.feed_period};
         REG_WARN_THRESHOLD: csr_prdata = {9'd0, cfg.warning_threshold};
         REG_AUTO_FEED_ON:   csr_prdata = {31'd0, cfg.auto_feed_on};
         REG_EARLY_WARN_ON:  csr_prdata = {31'd0, cfg.early_warning_on};
         REG_DEFAULT_ACTION: csr_prdata = {30'd0, cfg.warn_action};
         default:            csr_prdata = '0;
      endcase
   end

   wse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .ctl        (ctl)
   );

   wse_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cfg_wr   (cfg_wr),
      .ctl      (ctl),
      .status   (status),
      .cfg      (cfg),
      .result   (result)
   );

   assign rsp_tdata = result;

endmodule

// ===== tb/sv/watchdog_monitor.sv =====
// ----------------------------------------------------------------------------
// watchdog_monitor
// Watches the command, status and register ports of the watchdog supervisor,
// keeps its own copy of the watchdog state and compares every status
// transfer with the one predicted for the oldest outstanding command.
// ----------------------------------------------------------------------------
module watchdog_monitor
   import wse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [255:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic [31:0]  csr_prdata,
   input  logic         csr_pready,
   output int unsigned  fail_count,
   output int unsigned  pending
);

   // register copy
   logic [22:0] cfg_feed_iv;
   logic [22:0] cfg_warn_thr;
   logic        cfg_auto;
   logic        cfg_early;
   logic [1:0]  cfg_action;

   // watchdog state
   logic [31:0] clk_ms;
   logic [31:0] deadline;
   logic [31:0] next_auto;
   logic [31:0] last_fed;
   logic [22:0] arm_timeout;
   logic        armed;
   logic        warned;
   logic        auto_halted;
   logic [1:0]  mode_q;
   logic [31:0] feed_cnt;
   logic [31:0] miss_cnt;
   logic [31:0] warn_cnt;
   logic [31:0] gap_min;
   logic [31:0] gap_max;
   logic [31:0] gap_avg;

   result_type  due_status[$];
   int unsigned errors = 0;

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic logic try_feed(input logic veto);
      logic [31:0] gap;
      logic [63:0] num;
      logic [63:0] den;
      if (!armed)
         return 1'b0;
      if (veto) begin
         miss_cnt = miss_cnt + 1;
         return 1'b0;
      end
      gap = clk_ms - last_fed;
      if (feed_cnt == 0) begin
         gap_min = gap;
         gap_max = gap;
         gap_avg = gap;
      end else begin
         // full-width product, truncating divide
         num = {32'd0, gap_avg} * {32'd0, feed_cnt} + {32'd0, gap};
         den = {32'd0, feed_cnt} + 64'd1;
         if (gap < gap_min) gap_min = gap;
         if (gap > gap_max) gap_max = gap;
         gap_avg = 32'(num / den);
      end
      feed_cnt = feed_cnt + 1;
      last_fed = clk_ms;
      mode_q   = MODE_FEEDING;
      deadline = clk_ms + {9'd0, arm_timeout};
      warned   = 1'b0;
      return 1'b1;
   endfunction

   function automatic result_type apply_command(input logic [1:0] cmd, input logic [23:0] tmo,
                                                input logic veto, input logic ovr,
                                                input logic [1:0] ovr_act);
      result_type  res;
      logic        acc;
      logic        wev;
      logic        rreq;
      logic [31:0] rem;
      logic [1:0]  act;
      acc  = 1'b0;
      wev  = 1'b0;
      rreq = 1'b0;
      case (cmd)
         CMD_TICK: begin
            clk_ms = clk_ms + 1;
            if (armed) begin
               if (cfg_early && !warned) begin
                  rem = (clk_ms < deadline) ? deadline - clk_ms : 32'd0;
                  if (rem <= {9'd0, cfg_warn_thr}) begin
                     act      = ovr ? ovr_act : cfg_action;
                     warned   = 1'b1;
                     warn_cnt = warn_cnt + 1;
                     mode_q   = MODE_WARNING;
                     wev      = 1'b1;
                     rreq     = (act == ACT_RESET);
                  end
               end
               // a reset request skips the auto-feed of this tick
               if (!rreq && cfg_auto && !auto_halted && clk_ms >= next_auto) begin
                  if (try_feed(veto)) begin
                     next_auto = clk_ms + {9'd0, cfg_feed_iv};
                     acc = 1'b1;
                  end
               end
            end
         end
         CMD_FEED: acc = try_feed(veto);
         CMD_ENABLE: begin
            if (tmo >= TIMEOUT_LOW && tmo <= TIMEOUT_HIGH) begin
               arm_timeout = tmo[22:0];
               armed       = 1'b1;
               mode_q      = MODE_ENABLED;
               last_fed    = clk_ms;
               next_auto   = clk_ms + {9'd0, cfg_feed_iv};
               deadline    = clk_ms + {8'd0, tmo};
               warned      = 1'b0;
               acc         = 1'b1;
            end
         end
         default: begin
            // watchdog stays armed once started
            mode_q      = MODE_DISABLED;
            auto_halted = 1'b1;
            acc         = 1'b1;
         end
      endcase

      rem = (!armed || clk_ms >= deadline) ? 32'd0 : deadline - clk_ms;
      if (rem > {9'd0, REMAIN_MAX}) rem = {9'd0, REMAIN_MAX};
      res.pad           = '0;
      res.accepted      = acc;
      res.mode          = mode_q;
      res.warning_event = wev;
      res.reset_request = rreq;
      res.time_left     = rem[22:0];
      res.since_feed_ms = clk_ms - last_fed;
      res.feed_total    = feed_cnt;
      res.missed_total  = miss_cnt;
      res.warning_total = warn_cnt;
      res.interval_min  = gap_min;
      res.interval_max  = gap_max;
      res.interval_avg  = gap_avg;
      return res;
   endfunction

   always @(posedge clock) begin : track
      result_type  got;
      result_type  want;
      logic [31:0] rd_want;
      if (reset) begin
         cfg_feed_iv  = 23'd1000;
         cfg_warn_thr = 23'd1000;
         cfg_auto     = 1'b1;
         cfg_early    = 1'b1;
         cfg_action   = ACT_RESET;
         clk_ms       = '0;
         deadline     = '0;
         next_auto    = '0;
         last_fed     = '0;
         arm_timeout  = '0;
         armed        = 1'b0;
         warned       = 1'b0;
         auto_halted  = 1'b0;
         mode_q       = MODE_DISABLED;
         feed_cnt     = '0;
         miss_cnt     = '0;
         warn_cnt     = '0;
         gap_min      = '0;
         gap_max      = '0;
         gap_avg      = '0;
         due_status.delete();
      end else begin
         // compare before predicting so a stray status is never matched
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_status.size() == 0) begin
               $display("%0t: status transfer with none expected, expected none actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = due_status.pop_front();
               check_field("accepted", want.accepted, got.accepted);
               check_field("mode", want.mode, got.mode);
               check_field("warning_event", want.warning_event, got.warning_event);
               check_field("reset_request", want.reset_request, got.reset_request);
               check_field("time_left", want.time_left, got.time_left);
               check_field("since_feed_ms", want.since_feed_ms, got.since_feed_ms);
               check_field("feed_total", want.feed_total, got.feed_total);
               check_field("missed_total", want.missed_total, got.missed_total);
               check_field("warning_total", want.warning_total, got.warning_total);
               check_field("interval_min", want.interval_min, got.interval_min);
               check_field("interval_max", want.interval_max, got.interval_max);
               check_field("interval_avg", want.interval_avg, got.interval_avg);
               check_field("padding", want.pad, got.pad);
            end
         end

         if (req_tvalid && req_tready)
            due_status.push_back(apply_command(req_tuser, req_tdata[23:0], req_tdata[24],
                                               req_tdata[25], req_tdata[27:26]));

         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[4:2])
                  REG_FEED_INTERVAL:  cfg_feed_iv = csr_pwdata[22:0];
                  REG_WARN_THRESHOLD: cfg_warn_thr = csr_pwdata[22:0];
                  REG_AUTO_FEED_ON: begin
                     cfg_auto    = csr_pwdata[0];
                     auto_halted = 1'b0;
                  end
                  REG_EARLY_WARN_ON:  cfg_early = csr_pwdata[0];
                  REG_DEFAULT_ACTION: cfg_action = csr_pwdata[1:0];
                  default: ;
               endcase
            end else begin
               case (csr_paddr[4:2])
                  REG_FEED_INTERVAL:  rd_want = {9'd0, cfg_feed_iv};
                  REG_WARN_THRESHOLD: rd_want = {9'd0, cfg_warn_thr};
                  REG_AUTO_FEED_ON:   rd_want = {31'd0, cfg_auto};
                  REG_EARLY_WARN_ON:  rd_want = {31'd0, cfg_early};
                  REG_DEFAULT_ACTION: rd_want = {30'd0, cfg_action};
                  default:            rd_want = 32'd0;
               endcase
               check_field("register read", rd_want, csr_prdata);
            end
         end
      end
      fail_count <= errors;
      pending    <= due_status.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Command stimulus and verdict for the watchdog supervisor.
// ----------------------------------------------------------------------------
// Runs a directed sequence over the corner cases, then phases of random
// commands under several register settings with random stalls on both
// streams. Checking is done by watchdog_monitor beside the block.
// ----------------------------------------------------------------------------
module testbench;
   import wse_pkg::*;

   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 60;

   localparam logic [1:0] ACT_CALLBACK  = 2'd1;
   localparam logic [1:0] ACT_INTERRUPT = 2'd2;
   localparam logic [1:0] ACT_HALT      = 2'd3;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int unsigned  fail_count;
   int unsigned  pending;

   logic         quiet = 1'b0;
   logic         hold_req = 1'b0;
   logic         hold_done = 1'b0;
   int unsigned  hold_left = 0;
   int unsigned  idle_cycles = 0;

   watchdog_supervisor_early_warning dut (.*);

   watchdog_monitor u_monitor (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin : rsp_pacing
      int unsigned r;
      r = $urandom_range(0, 99);
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         // long hold-off so the block fills and stalls its input
         hold_done  <= 1'b1;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (quiet || r < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         hold_left  <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_cmd(input logic [1:0] cmd, input logic [23:0] tmo, input logic veto,
                           input logic ovr, input logic [1:0] act);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'd0, act, ovr, veto, tmo};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // psel stays high between back-to-back accesses; drop it with csr_psel <= 0
   task automatic csr_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                             input logic [31:0] val);
      csr_psel   <= 1'b1;
      csr_pwrite <= wr;
      csr_paddr  <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input int unsigned ph);
      logic [31:0]          iv;
      logic [31:0]          thr;
      logic [31:0]          af;
      logic [31:0]          ew;
      logic [31:0]          act;
      logic [31:0]          junk;
      logic [REG_IDX_W-1:0] idx;
      junk = (ph >= 3 && $urandom_range(0, 1) == 1) ? ($urandom & 32'hFF00_0000) : 32'd0;
      case (ph)
         0: begin
            iv = 32'd0; thr = 32'd0; af = 32'd1; ew = 32'd1; act = {30'd0, ACT_RESET};
         end
         1: begin
            iv = {9'd0, REMAIN_MAX}; thr = {9'd0, REMAIN_MAX}; af = 32'd0; ew = 32'd1;
            act = {30'd0, ACT_HALT};
         end
         2: begin
            iv = $urandom_range(0, 20); thr = $urandom_range(990, 1000); af = 32'd1;
            ew = 32'd1; act = {30'd0, ACT_CALLBACK};
         end
         PHASES - 1: begin
            iv = {9'd0, REMAIN_MAX}; thr = 32'd0; af = 32'd1; ew = 32'd0;
            act = {30'd0, ACT_INTERRUPT};
         end
         default: begin
            iv  = $urandom_range(0, 40);
            thr = ($urandom_range(0, 3) == 0) ? ($urandom & 32'h007F_FFFF)
                                               : $urandom_range(950, 1020);
            af  = ($urandom_range(0, 3) != 0);
            ew  = ($urandom_range(0, 3) != 0);
            act = $urandom_range(0, 3);
         end
      endcase
      csr_access(1'b1, REG_FEED_INTERVAL, iv | junk);
      csr_access(1'b1, REG_WARN_THRESHOLD, thr | junk);
      csr_access(1'b1, REG_AUTO_FEED_ON, af | junk);
      csr_access(1'b1, REG_EARLY_WARN_ON, ew | junk);
      csr_access(1'b1, REG_DEFAULT_ACTION, act | junk);
      for (int i = REG_FEED_INTERVAL; i <= REG_DEFAULT_ACTION; i++) begin
         idx = i;
         csr_access(1'b0, idx, 32'd0);
      end
      csr_psel <= 1'b0;
   endtask

   // mostly ticks with feeds and re-arms, some disables and a little noise
   task automatic random_cmd();
      int unsigned r;
      int unsigned pick;
      logic [23:0] tmo;
      logic        veto;
      logic        ovr;
      logic [1:0]  act;
      r    = $urandom_range(0, 99);
      tmo  = $urandom;
      veto = ($urandom_range(0, 6) == 0);
      ovr  = $urandom_range(0, 1);
      act  = $urandom_range(0, 3);
      if (r < 62) begin
         send_cmd(CMD_TICK, tmo, veto, ovr, act);
      end else if (r < 78) begin
         send_cmd(CMD_FEED, tmo, veto, ovr, act);
      end else if (r < 90) begin
         pick = $urandom_range(0, 9);
         if (pick < 7)
            tmo = $urandom_range(TIMEOUT_LOW, TIMEOUT_LOW + 40);
         else if (pick == 7)
            tmo = $urandom_range(TIMEOUT_LOW, TIMEOUT_HIGH);
         send_cmd(CMD_ENABLE, tmo, veto, ovr, act);
      end else if (r < 95) begin
         send_cmd(CMD_DISABLE, tmo, veto, ovr, act);
      end else begin
         send_cmd($urandom, tmo, veto, ovr, act);
      end
   endtask

   initial begin
      int unsigned ph;
      int unsigned n;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_TICK;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // not armed: ticks count, feeds refused and not missed
      send_cmd(CMD_TICK, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_FEED, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_FEED, 24'hFFFFFF, 1'b1, 1'b1, ACT_HALT);
      // timeout range edges
      send_cmd(CMD_ENABLE, TIMEOUT_LOW - 24'd1, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_ENABLE, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_ENABLE, TIMEOUT_HIGH + 24'd1, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_ENABLE, 24'hFFFFFF, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_ENABLE, TIMEOUT_HIGH, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_TICK, 24'd0, 1'b0, 1'b0, ACT_RESET);
      // re-arm while armed, then warn with reset action
      send_cmd(CMD_ENABLE, TIMEOUT_LOW, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_TICK, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_FEED, 24'd0, 1'b1, 1'b0, ACT_RESET);
      send_cmd(CMD_FEED, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_TICK, 24'd0, 1'b0, 1'b1, ACT_INTERRUPT);
      send_cmd(CMD_DISABLE, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_TICK, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_FEED, 24'd0, 1'b0, 1'b0, ACT_RESET);

      // short auto-feed period; writing auto_feed_on restarts auto-feed
      wait_drained();
      csr_access(1'b1, REG_FEED_INTERVAL, 32'd2);
      csr_access(1'b1, REG_AUTO_FEED_ON, 32'd1);
      csr_psel <= 1'b0;
      send_cmd(CMD_ENABLE, TIMEOUT_LOW, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_TICK, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_TICK, 24'd0, 1'b0, 1'b1, ACT_CALLBACK);
      send_cmd(CMD_TICK, 24'd0, 1'b1, 1'b0, ACT_RESET);
      send_cmd(CMD_TICK, 24'd0, 1'b1, 1'b0, ACT_RESET);
      send_cmd(CMD_TICK, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_DISABLE, 24'd0, 1'b0, 1'b0, ACT_RESET);
      send_cmd(CMD_TICK, 24'd0, 1'b0, 1'b0, ACT_RESET);

      for (ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         configure(ph);
         quiet    <= (ph == 2 || ph == 6);
         hold_req <= (ph == 4);
         for (n = 0; n < PHASE_ITEMS; n++)
            random_cmd();
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
